@@ rtl/dmsc_pkg.sv @@
package dmsc_pkg;

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_LEVEL = 2'd2,
        KIND_ENABLE = 2'd3
    } t_dmsc_kind;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_IRQ_ENABLE  = 3'd0,
        CFG_LOOP_ENABLE = 3'd1,
        CFG_RATE_INDEX  = 3'd2,
        CFG_START_ADDR  = 3'd3,
        CFG_LENGTH      = 3'd4
    } t_dmsc_cfg_index;

    localparam logic [15:0] WRAP_BASE = 16'h8000;
    localparam logic [15:0] ADDR_TOP  = 16'hFFFF;
    localparam logic [6:0]  LEVEL_MAX_STEP_UP = 7'd125;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        t_dmsc_kind  kind;
        logic [7:0]  value;
    } t_dmsc_in;

    typedef struct packed {
        logic [6:0]  level;
        logic        irq_flag;
        logic        bytes_done;
        logic        fetch_request;
        logic [15:0] fetch_address;
    } t_dmsc_out;

    // State of the output unit, shared between the top level and the unit.
    typedef struct packed {
        logic [6:0] level;
        logic [7:0] shift_bits;
        logic [3:0] bits_left;
        logic       silent;
    } t_dmsc_out_state;

    // Divider reload value: half the rate-table period, minus one.
    function automatic logic [7:0] rate_reload(input logic [3:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                4'd0:    r = 8'd213;
                4'd1:    r = 8'd189;
                4'd2:    r = 8'd169;
                4'd3:    r = 8'd159;
                4'd4:    r = 8'd142;
                4'd5:    r = 8'd126;
                4'd6:    r = 8'd112;
                4'd7:    r = 8'd106;
                4'd8:    r = 8'd94;
                4'd9:    r = 8'd79;
                4'd10:   r = 8'd70;
                4'd11:   r = 8'd63;
                4'd12:   r = 8'd52;
                4'd13:   r = 8'd41;
                4'd14:   r = 8'd35;
                4'd15:   r = 8'd26;
                default: r = 8'd213;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/dmsc_output_unit.sv @@
module dmsc_output_unit
    import dmsc_pkg::*;
(
    input  logic            i_clock_en,
    input  t_dmsc_out_state i_state,
    input  logic [7:0]      i_buffer_byte,
    input  logic            i_buffer_empty,
    output t_dmsc_out_state o_state,
    output logic            o_buffer_take
);

    // One output clock: step the level, shift, and reload every eight bits.
    always_comb begin
        o_state       = i_state;
        o_buffer_take = 1'b0;
        if (i_clock_en) begin
            if (!i_state.silent) begin
                if (i_state.shift_bits[0]) begin
                    if (i_state.level <= LEVEL_MAX_STEP_UP) begin
                        o_state.level = i_state.level + 7'd2;
                    end
                end else if (i_state.level >= 7'd2) begin
                    o_state.level = i_state.level - 7'd2;
                end
            end
            o_state.shift_bits = {1'b0, i_state.shift_bits[7:1]};
            if (i_state.bits_left <= 4'd1) begin
                o_state.bits_left = BITS_PER_BYTE;
                if (i_buffer_empty) begin
                    o_state.silent = 1'b1;
                end else begin
                    o_state.silent     = 1'b0;
                    o_state.shift_bits = i_buffer_byte;
                    o_buffer_take      = 1'b1;
                end
            end else begin
                o_state.bits_left = i_state.bits_left - 4'd1;
            end
        end
    end

endmodule

@@ rtl/delta_modulation_sample_channel.sv @@
// Delta-modulation sample channel. Each input word is a tick (one APU cycle), a
// sample byte returned by memory, a direct level load or an enable write, and
// each accepted word produces exactly one result word carrying the output level,
// the interrupt flag, the bytes-done status and, for ticks that start a read, the
// fetch request with its address (address and request are zero otherwise).
// The block has two register stages: an input register and a result register.
// All state is updated from the input register as its result word is registered, so
// a new word is taken every clock and the throughput is one word per cycle while
// no stall holds the result register. Each input word is captured in the input
// register and its result word in the result register. The result register holds
// while the downstream side stalls, and the input side then stalls with it.
// Configuration writes are taken at any edge with the write enable high, and
// must only be issued while no word is in flight; indexes beyond the register
// list are ignored. Writing zero to irq_enable clears the interrupt flag.
module delta_modulation_sample_channel
    import dmsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dmsc_in   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dmsc_out  o_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // Configuration registers.
    logic       r_irq_enable;
    logic       r_loop_enable;
    logic [3:0] r_rate_index;
    logic [7:0] r_start_code;
    logic [7:0] r_length_code;

    // Pipeline registers.
    logic      r_in_valid;
    t_dmsc_in  r_in;
    logic      r_out_valid;
    t_dmsc_out r_out;

    // Channel state and its next values.
    t_dmsc_out_state r_ou,           n_ou;
    logic [7:0]      r_buffer_byte,  n_buffer_byte;
    logic            r_buffer_empty, n_buffer_empty;
    logic            r_fetch_pending, n_fetch_pending;
    logic [15:0]     r_addr,         n_addr;
    logic [11:0]     r_bytes_left,   n_bytes_left;
    logic            r_irq_flag,     n_irq_flag;
    logic [7:0]      r_divider,      n_divider;
    t_dmsc_out       n_out;

    logic            advance;
    logic            is_tick;
    logic            do_fetch;
    logic            out_clock;
    logic            buffer_take;
    logic            cfg_irq_clear;
    t_dmsc_out_state ou_next;
    logic [15:0]     start_addr;
    logic [11:0]     start_len;
    logic [11:0]     bytes_dec;

    // The whole pipeline moves unless a finished result is held by a stall.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;

    assign start_addr = {2'b11, r_start_code, 6'b000000};
    assign start_len  = {r_length_code, 4'b0000} + 12'd1;
    assign bytes_dec  = r_bytes_left - 12'd1;

    assign is_tick   = r_in_valid && (r_in.kind == KIND_TICK);
    assign do_fetch  = is_tick && r_buffer_empty && !r_fetch_pending
                       && (r_bytes_left != 12'd0);
    assign out_clock = is_tick && (r_divider == 8'd0);

    assign cfg_irq_clear = i_cfg_we && (i_cfg_index == CFG_IRQ_ENABLE) && !i_cfg_data[0];

    dmsc_output_unit u_output_unit (
        .i_clock_en     (out_clock),
        .i_state        (r_ou),
        .i_buffer_byte  (r_buffer_byte),
        .i_buffer_empty (r_buffer_empty),
        .o_state        (ou_next),
        .o_buffer_take  (buffer_take)
    );

    always_comb begin
        n_ou            = r_ou;
        n_buffer_byte   = r_buffer_byte;
        n_buffer_empty  = r_buffer_empty;
        n_fetch_pending = r_fetch_pending;
        n_addr          = r_addr;
        n_bytes_left    = r_bytes_left;
        n_irq_flag      = r_irq_flag;
        n_divider       = r_divider;
        if (r_in_valid) begin
            case (r_in.kind)
                KIND_TICK: begin
                    // The memory reader runs before the output unit is clocked.
                    if (do_fetch) begin
                        n_fetch_pending = 1'b1;
                        n_addr = (r_addr == ADDR_TOP) ? WRAP_BASE : r_addr + 16'd1;
                        n_bytes_left = bytes_dec;
                        if (bytes_dec == 12'd0) begin
                            if (r_loop_enable) begin
                                n_addr       = start_addr;
                                n_bytes_left = start_len;
                            end else if (r_irq_enable) begin
                                n_irq_flag = 1'b1;
                            end
                        end
                    end
                    if (out_clock) begin
                        n_divider = rate_reload(r_rate_index);
                    end else begin
                        n_divider = r_divider - 8'd1;
                    end
                    n_ou = ou_next;
                    if (buffer_take) begin
                        n_buffer_byte  = 8'd0;
                        n_buffer_empty = 1'b1;
                    end
                end
                KIND_BYTE: begin
                    // A byte with no read outstanding is dropped.
                    if (r_fetch_pending) begin
                        n_buffer_byte   = r_in.value;
                        n_buffer_empty  = 1'b0;
                        n_fetch_pending = 1'b0;
                    end
                end
                KIND_LEVEL: begin
                    n_ou.level = r_in.value[6:0];
                end
                KIND_ENABLE: begin
                    if (!r_in.value[0]) begin
                        n_bytes_left = 12'd0;
                    end else if (r_bytes_left == 12'd0) begin
                        n_addr       = start_addr;
                        n_bytes_left = start_len;
                    end
                    n_irq_flag = 1'b0;
                end
                default: begin
                end
            endcase
        end

        n_out.level         = n_ou.level;
        n_out.irq_flag      = n_irq_flag;
        n_out.bytes_done    = (n_bytes_left == 12'd0);
        n_out.fetch_request = do_fetch;
        n_out.fetch_address = do_fetch ? r_addr : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_enable    <= 1'b0;
            r_loop_enable   <= 1'b0;
            r_rate_index    <= 4'd0;
            r_start_code    <= 8'd0;
            r_length_code   <= 8'd0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_ou            <= '{level: 7'd0, shift_bits: 8'd0, bits_left: 4'd0,
                                 silent: 1'b1};
            r_buffer_byte   <= 8'd0;
            r_buffer_empty  <= 1'b1;
            r_fetch_pending <= 1'b0;
            r_addr          <= 16'd0;
            r_bytes_left    <= 12'd0;
            r_irq_flag      <= 1'b0;
            r_divider       <= 8'd0;
        end else begin
            if (advance) begin
                r_in_valid      <= i_in_valid;
                r_out_valid     <= r_in_valid;
                r_ou            <= n_ou;
                r_buffer_byte   <= n_buffer_byte;
                r_buffer_empty  <= n_buffer_empty;
                r_fetch_pending <= n_fetch_pending;
                r_addr          <= n_addr;
                r_bytes_left    <= n_bytes_left;
                r_divider       <= n_divider;
            end
            // Clearing irq_enable wins over any item update of the flag.
            if (cfg_irq_clear) begin
                r_irq_flag <= 1'b0;
            end else if (advance) begin
                r_irq_flag <= n_irq_flag;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IRQ_ENABLE:  r_irq_enable  <= i_cfg_data[0];
                    CFG_LOOP_ENABLE: r_loop_enable <= i_cfg_data[0];
                    CFG_RATE_INDEX:  r_rate_index  <= i_cfg_data[3:0];
                    CFG_START_ADDR:  r_start_code  <= i_cfg_data;
                    CFG_LENGTH:      r_length_code <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in  <= i_in;
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // While a read is outstanding the one-byte buffer must stay empty.
    a_pending_buffer_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch_pending |-> r_buffer_empty)
        else $error("fetch outstanding while sample buffer is full");

    // A requested address always lies in the upper half of the address space.
    a_fetch_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fetch_request) |-> r_out.fetch_address[15])
        else $error("fetch address below the sample region");

    // Clearing irq_enable clears the interrupt flag at once.
    a_irq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == CFG_IRQ_ENABLE) && !i_cfg_data[0]) |=> !r_irq_flag)
        else $error("interrupt flag survived an irq_enable clear");

    // The output bit counter never exceeds one byte.
    a_bits_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ou.bits_left <= BITS_PER_BYTE)
        else $error("output bit counter out of range");

endmodule
